@@ rtl/hcbp_pkg.sv @@
// Shared types and constants of the Huffman code bit packer.
package hcbp_pkg;

    localparam int SYM_W       = 8;
    localparam int CODE_W      = 32;
    localparam int CLEN_W      = 6;
    localparam int BYTE_W      = 8;
    localparam int PEND_W      = 7;
    localparam int HDR_W       = 3;
    localparam int DEF_DEPTH   = 256;
    localparam int DEF_MAX_LEN = 32;

    typedef enum logic [1:0] {
        REQ_LOAD   = 2'd0,
        REQ_ENCODE = 2'd1,
        REQ_FINISH = 2'd2
    } t_req_type;

    typedef struct packed {
        t_req_type           req_type;
        logic [SYM_W-1:0]    symbol;
        logic [CODE_W-1:0]   code_bits;
        logic [CLEN_W-1:0]   code_len;
    } t_in_req;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              is_header;
        logic              last;
    } t_out_res;

endpackage

@@ rtl/hcbp_req_if.sv @@
// Request and result channels of the Huffman code bit packer.
interface hcbp_req_if;
    import hcbp_pkg::*;

    logic    valid;
    logic    ready;
    t_in_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface hcbp_res_if;
    import hcbp_pkg::*;

    logic     valid;
    logic     ready;
    t_out_res data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/huffman_code_bit_packer.sv @@
// Huffman code bit packer: code table, bit buffer and byte output register.
//
// A load request writes one code table entry. An encode or finish request passes the
// table read register, then its bytes are built in one pass and leave the result
// register one per cycle while the receiver is ready; the next request moves up as
// the last byte of the previous one is taken. An encode whose code brings the buffer
// to (pending + length) bits gives floor of that over 8 bytes, at most 4 with 32-bit
// codes, and a finish gives one or two. Table entries carry valid bits cleared by
// reset, so the block is usable right after reset with no clearing pass.
module huffman_code_bit_packer #(
    parameter int TABLE_DEPTH  = hcbp_pkg::DEF_DEPTH,
    parameter int MAX_CODE_LEN = hcbp_pkg::DEF_MAX_LEN
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    hcbp_req_if.sink     i_req,
    hcbp_res_if.source   o_res
);
    import hcbp_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int LEN_W = $clog2(MAX_CODE_LEN + 1);
    localparam int ACC_W = MAX_CODE_LEN + PEND_W;
    localparam int TOT_W = $clog2(ACC_W + 1);
    localparam int CNT_W = $clog2(ACC_W / BYTE_W + 1);

    typedef struct packed {
        logic [LEN_W-1:0]        len;
        logic [MAX_CODE_LEN-1:0] code;
    } t_entry;

    t_entry                  r_mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]  r_tv;

    logic                    r_rd_v;
    t_entry                  r_rd;
    logic                    r_s1_v;
    logic                    r_s1_fin;

    logic [PEND_W-1:0]       r_pend;
    logic [HDR_W-1:0]        r_pcnt;

    logic [ACC_W-1:0]        r_ob_word;
    logic [CNT_W-1:0]        r_ob_cnt;
    logic                    r_ob_hdr;
    logic [HDR_W-1:0]        r_ob_hval;

    logic                    accept;
    logic                    in_range;
    logic [IDX_W-1:0]        idx;
    logic [LEN_W-1:0]        clen_sat;
    logic [CODE_W-1:0]       code_masked;
    logic [CODE_W+MAX_CODE_LEN-1:0] code_wide;
    t_entry                  wr_entry;

    logic                    out_last;
    logic                    ob_free;
    logic                    s1_fire;
    logic [LEN_W-1:0]        e_len;
    logic [MAX_CODE_LEN-1:0] e_code;
    logic [ACC_W-1:0]        word;
    logic [TOT_W-1:0]        total;
    logic [CNT_W-1:0]        nbytes;
    logic [ACC_W-1:0]        word_sh;

    // input side and table write data
    assign accept   = i_req.valid && i_req.ready;
    assign in_range = {1'b0, i_req.data.symbol} < (SYM_W + 1)'(TABLE_DEPTH);
    assign idx      = i_req.data.symbol[IDX_W-1:0];

    always_comb begin
        if ({1'b0, i_req.data.code_len} > (CLEN_W + 1)'(MAX_CODE_LEN)) begin
            clen_sat = LEN_W'(MAX_CODE_LEN);
        end else begin
            clen_sat = LEN_W'(i_req.data.code_len);
        end
        code_masked   = i_req.data.code_bits & ~({CODE_W{1'b1}} << clen_sat);
        code_wide     = {code_masked, {MAX_CODE_LEN{1'b0}}} >> clen_sat;
        wr_entry.len  = clen_sat;
        wr_entry.code = code_wide[MAX_CODE_LEN-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_req.data.req_type == REQ_LOAD && in_range) begin
            r_mem[idx] <= wr_entry;
        end
        if (accept) begin
            r_rd <= r_mem[idx];
        end
    end

    // result register side
    assign o_res.valid          = (r_ob_cnt != '0) || r_ob_hdr;
    assign out_last             = (r_ob_cnt == '0) || (r_ob_cnt == CNT_W'(1) && !r_ob_hdr);
    assign o_res.data.out_byte  = (r_ob_cnt != '0) ? r_ob_word[ACC_W-1 -: BYTE_W]
                                                   : BYTE_W'(r_ob_hval);
    assign o_res.data.is_header = (r_ob_cnt == '0);
    assign o_res.data.last      = out_last;

    assign ob_free     = !o_res.valid || (o_res.ready && out_last);
    assign s1_fire     = r_s1_v && ob_free;
    assign i_req.ready = !r_s1_v || s1_fire;

    // merge pending bits with the left-aligned code, then split off whole bytes
    always_comb begin
        e_len   = r_rd_v ? r_rd.len  : '0;
        e_code  = r_rd_v ? r_rd.code : '0;
        word    = {r_pend, {MAX_CODE_LEN{1'b0}}} | ({e_code, {PEND_W{1'b0}}} >> r_pcnt);
        total   = TOT_W'(r_pcnt) + TOT_W'(e_len);
        nbytes  = CNT_W'(total >> 3);
        word_sh = word << {nbytes, 3'b000};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tv     <= '0;
            r_rd_v   <= 1'b0;
            r_s1_v   <= 1'b0;
            r_s1_fin <= 1'b0;
            r_pend   <= '0;
            r_pcnt   <= '0;
            r_ob_cnt <= '0;
            r_ob_hdr <= 1'b0;
        end else begin
            if (accept && i_req.data.req_type == REQ_LOAD && in_range) begin
                r_tv[idx] <= 1'b1;
            end
            if (accept) begin
                r_rd_v   <= r_tv[idx] && in_range;
                r_s1_v   <= (i_req.data.req_type == REQ_ENCODE)
                         || (i_req.data.req_type == REQ_FINISH);
                r_s1_fin <= (i_req.data.req_type == REQ_FINISH);
            end else if (s1_fire) begin
                r_s1_v <= 1'b0;
            end

            if (s1_fire) begin
                if (r_s1_fin) begin
                    r_ob_word <= {r_pend, {MAX_CODE_LEN{1'b0}}};
                    r_ob_cnt  <= (r_pcnt != '0) ? CNT_W'(1) : '0;
                    r_ob_hdr  <= 1'b1;
                    r_ob_hval <= r_pcnt;
                    r_pend    <= '0;
                    r_pcnt    <= '0;
                end else begin
                    r_ob_word <= word;
                    r_ob_cnt  <= nbytes;
                    r_ob_hdr  <= 1'b0;
                    r_pend    <= word_sh[ACC_W-1 -: PEND_W];
                    r_pcnt    <= total[HDR_W-1:0];
                end
            end else if (o_res.valid && o_res.ready) begin
                if (r_ob_cnt != '0) begin
                    r_ob_cnt  <= r_ob_cnt - CNT_W'(1);
                    r_ob_word <= r_ob_word << BYTE_W;
                end else begin
                    r_ob_hdr <= 1'b0;
                end
            end
        end
    end

`ifndef ASSERT_OFF
    a_pend_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        PEND_W'(r_pend << r_pcnt) == '0)
        else $error("pending bits beyond count not clear");

    a_finish_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire && r_s1_fin |=> r_pcnt == '0 && r_pend == '0)
        else $error("bit buffer not empty after finish");

    a_header_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.data.is_header |-> o_res.data.last)
        else $error("header not flagged last");

    a_fire_into_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire && o_res.valid |-> o_res.ready && out_last)
        else $error("result register overwritten");
`endif

endmodule

@@ tb/huffman_code_bit_packer_tb.sv @@
// Self-checking testbench of the Huffman code bit packer: random request stream, byte predictor.
module huffman_code_bit_packer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hcbp_pkg::*;

    localparam int        CLK_HALF     = 6;
    localparam int        DEPTH        = DEF_DEPTH;
    localparam int        MAX_LEN      = DEF_MAX_LEN;
    localparam int        RANDOM_ITEMS = 330;
    localparam int        WARM_LOADS   = 16;
    localparam int        CALM_TAIL    = 60;
    localparam int        HOLD_AT      = 150;
    localparam int        HOLD_CYCLES  = 90;
    localparam int        DRAIN_CYCLES = 20;
    localparam t_req_type REQ_UNUSED   = t_req_type'(2'd3);

    logic i_clk;
    logic i_rst_n;

    hcbp_req_if req_ch ();
    hcbp_res_if res_ch ();

    huffman_code_bit_packer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch)
    );

    t_in_req           pending_reqs[$];
    t_out_res          expected_bytes[$];
    logic [CODE_W-1:0] code_word[DEPTH];
    logic [CLEN_W-1:0] code_size[DEPTH];
    logic [PEND_W-1:0] carry_bits;
    logic [HDR_W-1:0]  carry_count;

    int error_count   = 0;
    int total_reqs    = 0;
    int reqs_accepted = 0;
    bit req_taken     = 1'b0;
    int send_gap      = 0;
    int take_gap      = 0;
    int hold_left     = 0;
    bit hold_done     = 1'b0;

    initial begin
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        res_ch.ready = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("huffman_code_bit_packer_tb: done, errors");
        $finish;
    end

    task automatic report_mismatch(string what, int got, int want);
        error_count++;
        $display("%0t mismatch, %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
    endtask

    task automatic queue_request(t_req_type kind, logic [SYM_W-1:0] sym,
                                 logic [CODE_W-1:0] bits, logic [CLEN_W-1:0] len);
        t_in_req r;
        r.req_type  = kind;
        r.symbol    = sym;
        r.code_bits = bits;
        r.code_len  = len;
        pending_reqs.push_back(r);
    endtask

    task automatic pack_request(t_in_req r);
        t_out_res    bytes_out[4];
        int          n;
        int          len;
        int          total;
        logic [63:0] acc;
        n = 0;
        case (r.req_type)
            REQ_LOAD: begin
                if (r.symbol < DEPTH) begin
                    len = (r.code_len > MAX_LEN) ? MAX_LEN : r.code_len;
                    code_word[r.symbol] = CODE_W'(r.code_bits & ((64'd1 << len) - 64'd1));
                    code_size[r.symbol] = CLEN_W'(len);
                end
            end
            REQ_ENCODE: begin
                len = (r.symbol < DEPTH) ? code_size[r.symbol] : 0;
                if (len > 0) begin
                    acc   = (64'(carry_bits) << len) | 64'(code_word[r.symbol]);
                    total = carry_count + len;
                    while (total >= BYTE_W) begin
                        total                  -= BYTE_W;
                        bytes_out[n].out_byte  = BYTE_W'(acc >> total);
                        bytes_out[n].is_header = 1'b0;
                        bytes_out[n].last      = 1'b0;
                        n++;
                    end
                    carry_bits  = PEND_W'(acc & ((64'd1 << total) - 64'd1));
                    carry_count = HDR_W'(total);
                end
            end
            REQ_FINISH: begin
                if (carry_count != 0) begin
                    bytes_out[n].out_byte  = BYTE_W'({carry_bits, 1'b0} << (PEND_W - carry_count));
                    bytes_out[n].is_header = 1'b0;
                    bytes_out[n].last      = 1'b0;
                    n++;
                end
                bytes_out[n].out_byte  = BYTE_W'(carry_count);
                bytes_out[n].is_header = 1'b1;
                bytes_out[n].last      = 1'b0;
                n++;
                carry_bits  = '0;
                carry_count = '0;
            end
            default: begin
            end
        endcase
        for (int k = 0; k < n; k++) begin
            bytes_out[k].last = (k == n - 1);
            expected_bytes.push_back(bytes_out[k]);
        end
    endtask

    task automatic check_byte(t_out_res got);
        t_out_res want;
        if (expected_bytes.size() == 0) begin
            report_mismatch("byte with nothing expected", int'(got.out_byte), 0);
        end else begin
            want = expected_bytes.pop_front();
            if (got.out_byte !== want.out_byte) begin
                report_mismatch("out_byte", int'(got.out_byte), int'(want.out_byte));
            end
            if (got.is_header !== want.is_header) begin
                report_mismatch("is_header", int'(got.is_header), int'(want.is_header));
            end
            if (got.last !== want.last) begin
                report_mismatch("last", int'(got.last), int'(want.last));
            end
        end
    endtask

    initial begin
        for (int s = 0; s < DEPTH; s++) begin
            code_word[s] = '0;
            code_size[s] = '0;
        end
        carry_bits  = '0;
        carry_count = '0;
    end

    always @(posedge i_clk) begin
        req_taken = i_rst_n && req_ch.valid && req_ch.ready;
        if (req_taken) begin
            pack_request(req_ch.data);
            reqs_accepted++;
        end
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            check_byte(res_ch.data);
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else if (req_ch.valid && !req_taken) begin
            // hold the offered request
        end else if (send_gap > 0) begin
            send_gap     <= send_gap - 1;
            req_ch.valid <= 1'b0;
        end else if (pending_reqs.size() > 0 && hold_left == 0
                     && reqs_accepted + CALM_TAIL < total_reqs
                     && $urandom_range(0, 9) == 0) begin
            send_gap     <= $urandom_range(0, 13);
            req_ch.valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
            req_ch.data  <= pending_reqs.pop_front();
            req_ch.valid <= 1'b1;
        end else begin
            req_ch.valid <= 1'b0;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            res_ch.ready <= 1'b0;
        end else if (take_gap > 0) begin
            take_gap     <= take_gap - 1;
            res_ch.ready <= 1'b0;
        end else if (reqs_accepted + CALM_TAIL < total_reqs && $urandom_range(0, 7) == 0) begin
            take_gap     <= $urandom_range(0, 13);
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= 1'b1;
        end
    end

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && reqs_accepted >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    initial begin
        int               pick;
        int               len;
        logic [SYM_W-1:0] sym;
        logic [SYM_W-1:0] known_syms[$];

        queue_request(REQ_FINISH, 8'd0, 32'h0, 6'd0);
        queue_request(REQ_LOAD, 8'd0, 32'hFFFF_FFFF, 6'd32);
        queue_request(REQ_LOAD, 8'd255, 32'h1, 6'd1);
        queue_request(REQ_LOAD, 8'd7, 32'hA5A5_5A5A, 6'd63);
        queue_request(REQ_LOAD, 8'd8, 32'h0000_FFFF, 6'd0);
        queue_request(REQ_LOAD, 8'd9, 32'hFFFF_FFE0, 6'd5);
        queue_request(REQ_LOAD, 8'd10, 32'h55, 6'd7);
        queue_request(REQ_ENCODE, 8'd255, 32'h0, 6'd0);
        queue_request(REQ_ENCODE, 8'd0, 32'h0, 6'd0);
        queue_request(REQ_ENCODE, 8'd7, 32'h0, 6'd0);
        queue_request(REQ_ENCODE, 8'd8, 32'h0, 6'd0);
        queue_request(REQ_ENCODE, 8'd200, 32'h0, 6'd0);
        queue_request(REQ_UNUSED, 8'd255, 32'hFFFF_FFFF, 6'd63);
        queue_request(REQ_ENCODE, 8'd10, 32'hFFFF_FFFF, 6'd63);
        queue_request(REQ_ENCODE, 8'd255, 32'h0, 6'd0);
        queue_request(REQ_FINISH, 8'd0, 32'h0, 6'd0);
        queue_request(REQ_FINISH, 8'd255, 32'hFFFF_FFFF, 6'd63);
        queue_request(REQ_ENCODE, 8'd9, 32'h0, 6'd0);
        queue_request(REQ_FINISH, 8'd0, 32'h0, 6'd0);
        queue_request(REQ_LOAD, 8'd255, 32'hFFFF_FFFF, 6'd40);
        queue_request(REQ_ENCODE, 8'd255, 32'h0, 6'd0);
        queue_request(REQ_FINISH, 8'd0, 32'h0, 6'd0);

        for (int n = 0; n < WARM_LOADS; n++) begin
            sym = SYM_W'($urandom_range(0, 255));
            known_syms.push_back(sym);
            queue_request(REQ_LOAD, sym, $urandom, CLEN_W'($urandom_range(1, MAX_LEN)));
        end
        for (int n = WARM_LOADS; n < RANDOM_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                sym = SYM_W'($urandom_range(0, 255));
                case ($urandom_range(0, 9))
                    0:       len = 0;
                    1:       len = $urandom_range(MAX_LEN + 1, 63);
                    2, 3, 4: len = $urandom_range(1, 12);
                    default: len = $urandom_range(1, MAX_LEN);
                endcase
                known_syms.push_back(sym);
                queue_request(REQ_LOAD, sym, $urandom, CLEN_W'(len));
            end else if (pick < 88) begin
                if ($urandom_range(0, 9) == 0) begin
                    sym = SYM_W'($urandom_range(0, 255));
                end else begin
                    sym = known_syms[$urandom_range(0, known_syms.size() - 1)];
                end
                queue_request(REQ_ENCODE, sym, $urandom, CLEN_W'($urandom_range(0, 63)));
            end else if (pick < 96) begin
                queue_request(REQ_FINISH, SYM_W'($urandom_range(0, 255)), $urandom,
                              CLEN_W'($urandom_range(0, 63)));
            end else begin
                queue_request(REQ_UNUSED, SYM_W'($urandom_range(0, 255)), $urandom,
                              CLEN_W'($urandom_range(0, 63)));
            end
        end
        queue_request(REQ_FINISH, 8'd0, 32'h0, 6'd0);
        total_reqs = pending_reqs.size();

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (reqs_accepted < total_reqs) @(negedge i_clk);
        while (expected_bytes.size() > 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (error_count == 0) begin
            $display("huffman_code_bit_packer_tb: done, clean");
        end else begin
            $display("huffman_code_bit_packer_tb: done, errors");
        end
        $finish;
    end

endmodule
